// ----- rtl/dsrb_pkg.sv -----
// ----------------------------------------------------------------------------
// dsrb_pkg
// shared widths, marker codes and register indexes of the stencil row builder
// ----------------------------------------------------------------------------
package dsrb_pkg;

	localparam int COEF_W   = 31;
	localparam int VAL_W    = 32;
	localparam int MARK_W   = 14;
	localparam int NBR_N    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam int PROD_W   = 64;
	localparam int TERM_W   = 48;
	localparam int ACC_W    = 51;
	localparam int DIAG_W   = 34;

	localparam logic [1:0] MK_FLUID    = 2'd0;
	localparam logic [1:0] MK_AIR      = 2'd1;
	localparam logic [1:0] MK_BOUNDARY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Z    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIRICHLET = 2'd3;

	localparam logic [DIAG_W-1:0] ONE_Q16   = 34'd65536;
	localparam logic [DIAG_W-1:0] DIAG_MAX  = 34'h0_7FFF_FFFF;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;
	localparam logic signed [VAL_W-1:0] RHS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] RHS_MIN = 32'sh8000_0000;

	localparam logic DIRICHLET_RESET = 1'b1;

endpackage

// ----- rtl/dsrb_if.sv -----
// ----------------------------------------------------------------------------
// dsrb request and row channels
// valid/ready channels for cell requests and assembled rows
// ----------------------------------------------------------------------------
interface dsrb_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [dsrb_pkg::MARK_W-1:0]           marker_pack;
	logic [dsrb_pkg::NBR_N-1:0]            neighbor_present;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_center;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_xplus;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_xminus;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_yplus;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_yminus;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_zplus;
	logic signed [dsrb_pkg::VAL_W-1:0]     value_zminus;

	modport source (
		output valid, marker_pack, neighbor_present, value_center, value_xplus,
		       value_xminus, value_yplus, value_yminus, value_zplus, value_zminus,
		input  ready
	);
	modport sink (
		input  valid, marker_pack, neighbor_present, value_center, value_xplus,
		       value_xminus, value_yplus, value_yminus, value_zplus, value_zminus,
		output ready
	);
endinterface

interface dsrb_row_if;
	logic                                  valid;
	logic                                  ready;
	logic [dsrb_pkg::COEF_W-1:0]           diagonal;
	logic signed [dsrb_pkg::VAL_W-1:0]     coef_right;
	logic signed [dsrb_pkg::VAL_W-1:0]     coef_up;
	logic signed [dsrb_pkg::VAL_W-1:0]     coef_front;
	logic signed [dsrb_pkg::VAL_W-1:0]     rhs;

	modport source (
		output valid, diagonal, coef_right, coef_up, coef_front, rhs,
		input  ready
	);
	modport sink (
		input  valid, diagonal, coef_right, coef_up, coef_front, rhs,
		output ready
	);
endinterface

// ----- rtl/dsrb_bnd_term.sv -----
// ----------------------------------------------------------------------------
// dsrb_bnd_term
// one boundary lane: coefficient times neighbor value, then rounded to q16.16
// ----------------------------------------------------------------------------
module dsrb_bnd_term (
	input  logic                                 clk,
	input  logic                                 en_s2,
	input  logic                                 en_s3,
	input  logic                                 use_bnd,
	input  logic [dsrb_pkg::COEF_W-1:0]          coef,
	input  logic signed [dsrb_pkg::VAL_W-1:0]    value,
	output logic signed [dsrb_pkg::TERM_W-1:0]   term_s3
);

	logic signed [dsrb_pkg::PROD_W-1:0] prod;
	logic signed [dsrb_pkg::PROD_W-1:0] prod_s2;
	logic signed [dsrb_pkg::PROD_W-1:0] rnd;

	assign prod = $signed({1'b0, coef}) * value;
	assign rnd  = (prod_s2 + dsrb_pkg::ROUND_HALF) >>> 16;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= use_bnd ? prod : '0;
		end
		if (en_s3) begin
			term_s3 <= rnd[dsrb_pkg::TERM_W-1:0];
		end
	end

endmodule

// ----- rtl/diffusion_stencil_row_builder.sv -----
// ----------------------------------------------------------------------------
// diffusion_stencil_row_builder
// assembles one backward euler 7-point diffusion row per grid cell
// ----------------------------------------------------------------------------
// usage:
//   req_in carries one cell request: markers, neighbor presence and seven
//   q16.16 values. row_out returns the diagonal, the x+/y+/z+ off-diagonals
//   and the saturated right-hand side, one row per request, in order.
//   cfg_we/cfg_idx/cfg_wdata write coef_x, coef_y, coef_z and dirichlet_mode;
//   write them only while no request is in flight.
// timing:
//   four register stages (input, products, rounded terms, row); a request
//   passes through them in order. one request per cycle is sustained while
//   row_out is ready; the depth is set by the six boundary multipliers, one
//   per neighbor, and the rounding and summing that follow them.
// reset:
//   arst_n clears all stage valids and the coefficients; dirichlet mode
//   comes up enabled.
// stall:
//   when row_out is not ready the stages fill up one by one; req_in.ready
//   drops only once every stage holds a request.
// ----------------------------------------------------------------------------
module diffusion_stencil_row_builder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dsrb_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [dsrb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	dsrb_req_if.sink                             req_in,
	dsrb_row_if.source                           row_out
);

	logic [dsrb_pkg::COEF_W-1:0] coef_q [3];
	logic                        dir_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [dsrb_pkg::MARK_W-1:0]        mk_s1;
	logic [dsrb_pkg::NBR_N-1:0]         pr_s1;
	logic signed [dsrb_pkg::VAL_W-1:0]  val_s1 [7];

	logic [dsrb_pkg::COEF_W-1:0]        diag_s2, diag_s3, diag_s4;
	logic signed [dsrb_pkg::VAL_W-1:0]  offd_s2 [3];
	logic signed [dsrb_pkg::VAL_W-1:0]  offd_s3 [3];
	logic signed [dsrb_pkg::VAL_W-1:0]  offd_s4 [3];
	logic signed [dsrb_pkg::VAL_W-1:0]  ctr_s2, ctr_s3;
	logic signed [dsrb_pkg::VAL_W-1:0]  rhs_s4;

	logic                               self_fluid;
	logic [dsrb_pkg::NBR_N-1:0]         use_bnd;
	logic [dsrb_pkg::NBR_N-1:0]         cnt_diag;
	logic [dsrb_pkg::NBR_N-1:0]         is_fluid;
	logic [dsrb_pkg::DIAG_W-1:0]        diag_acc;
	logic [dsrb_pkg::COEF_W-1:0]        diag_sat;
	logic signed [dsrb_pkg::VAL_W-1:0]  offd_nxt [3];
	logic signed [dsrb_pkg::TERM_W-1:0] term_s3 [dsrb_pkg::NBR_N];
	logic signed [dsrb_pkg::ACC_W-1:0]  rhs_acc;
	logic signed [dsrb_pkg::VAL_W-1:0]  rhs_sat;

	// handshake and stage advance
	assign rdy4 = !v_s4 || row_out.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= '0;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			dir_q     <= dsrb_pkg::DIRICHLET_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				dsrb_pkg::REG_COEF_X:    coef_q[0] <= cfg_wdata;
				dsrb_pkg::REG_COEF_Y:    coef_q[1] <= cfg_wdata;
				dsrb_pkg::REG_COEF_Z:    coef_q[2] <= cfg_wdata;
				dsrb_pkg::REG_DIRICHLET: dir_q     <= cfg_wdata[0];
				default:                 dir_q     <= dir_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy1) begin
			mk_s1     <= req_in.marker_pack;
			pr_s1     <= req_in.neighbor_present;
			val_s1[0] <= req_in.value_center;
			val_s1[1] <= req_in.value_xplus;
			val_s1[2] <= req_in.value_xminus;
			val_s1[3] <= req_in.value_yplus;
			val_s1[4] <= req_in.value_yminus;
			val_s1[5] <= req_in.value_zplus;
			val_s1[6] <= req_in.value_zminus;
		end
	end

	// neighbor classification, diagonal and off-diagonals
	always_comb begin
		logic [1:0] code;
		self_fluid = mk_s1[1:0] == dsrb_pkg::MK_FLUID;
		diag_acc   = dsrb_pkg::ONE_Q16;
		for (int n = 0; n < dsrb_pkg::NBR_N; n++) begin
			code        = mk_s1[2 + 2*n +: 2];
			is_fluid[n] = self_fluid && pr_s1[n] && (code == dsrb_pkg::MK_FLUID);
			// air is ignored, boundary and the spare code count as boundary
			use_bnd[n]  = self_fluid && pr_s1[n] && dir_q && code[1];
			cnt_diag[n] = is_fluid[n] || use_bnd[n];
			if (cnt_diag[n]) begin
				diag_acc = diag_acc + {3'b000, coef_q[n/2]};
			end
		end
		if (diag_acc > dsrb_pkg::DIAG_MAX) begin
			diag_sat = dsrb_pkg::DIAG_MAX[dsrb_pkg::COEF_W-1:0];
		end else begin
			diag_sat = diag_acc[dsrb_pkg::COEF_W-1:0];
		end
		for (int a = 0; a < 3; a++) begin
			offd_nxt[a] = is_fluid[2*a] ? (32'sd0 - $signed({1'b0, coef_q[a]})) : 32'sd0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < dsrb_pkg::NBR_N; g++) begin : g_lane
			dsrb_bnd_term u_term (
				.clk     (clk),
				.en_s2   (rdy2),
				.en_s3   (rdy3),
				.use_bnd (use_bnd[g]),
				.coef    (coef_q[g/2]),
				.value   (val_s1[g+1]),
				.term_s3 (term_s3[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (rdy2) begin
			diag_s2 <= diag_sat;
			offd_s2 <= offd_nxt;
			ctr_s2  <= val_s1[0];
		end
		if (rdy3) begin
			diag_s3 <= diag_s2;
			offd_s3 <= offd_s2;
			ctr_s3  <= ctr_s2;
		end
	end

	// right-hand side sum and saturation
	always_comb begin
		rhs_acc = dsrb_pkg::ACC_W'(ctr_s3);
		for (int n = 0; n < dsrb_pkg::NBR_N; n++) begin
			rhs_acc = rhs_acc + dsrb_pkg::ACC_W'(term_s3[n]);
		end
		if (rhs_acc > dsrb_pkg::ACC_W'(dsrb_pkg::RHS_MAX)) begin
			rhs_sat = dsrb_pkg::RHS_MAX;
		end else if (rhs_acc < dsrb_pkg::ACC_W'(dsrb_pkg::RHS_MIN)) begin
			rhs_sat = dsrb_pkg::RHS_MIN;
		end else begin
			rhs_sat = rhs_acc[dsrb_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			diag_s4 <= diag_s3;
			offd_s4 <= offd_s3;
			rhs_s4  <= rhs_sat;
		end
	end

	assign row_out.valid      = v_s4;
	assign row_out.diagonal   = diag_s4;
	assign row_out.coef_right = offd_s4[0];
	assign row_out.coef_up    = offd_s4[1];
	assign row_out.coef_front = offd_s4[2];
	assign row_out.rhs        = rhs_s4;

endmodule
